FILE: src/chromaticity_color_key_mask_unit_defines.svh
// Assertion macros shared by the chromaticity color key mask unit.
`ifndef CHROMATICITY_COLOR_KEY_MASK_UNIT_DEFINES_SVH
`define CHROMATICITY_COLOR_KEY_MASK_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CCM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccm: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccm: next-cycle check failed");

`endif

FILE: src/ccm_pkg.sv
// Shared types and constants of the chromaticity color key mask unit.
package ccm_pkg;

  localparam int CHAN_W      = 8;
  localparam int SUM_W       = 10;
  localparam int NUM_W       = 16;
  localparam int REM_W       = NUM_W + 1;
  localparam int QUO_W       = 8;
  localparam int DIV_STEPS   = QUO_W;
  localparam int NORM_STAGES = DIV_STEPS + 2;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;
  localparam logic [CHAN_W-1:0] MASK_ON   = 8'hFF;
  localparam logic [CHAN_W-1:0] MASK_OFF  = 8'h00;

  localparam logic [CHAN_W-1:0] RST_REF_BLUE  = 8'd0;
  localparam logic [CHAN_W-1:0] RST_REF_GREEN = 8'd0;
  localparam logic [CHAN_W-1:0] RST_REF_RED   = 8'd255;
  localparam logic [CHAN_W-1:0] RST_THRESHOLD = 8'd150;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } bgr_t;

  typedef enum logic [1:0] {
    REG_REF_BLUE        = 2'd0,
    REG_REF_GREEN       = 2'd1,
    REG_REF_RED         = 2'd2,
    REG_MATCH_THRESHOLD = 2'd3
  } cfg_reg_t;

endpackage

FILE: src/ccm_cfg_regs.sv
// Configuration register file with an APB-style write and read port.
module ccm_cfg_regs import ccm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output bgr_t                  key_color,
  output logic [CHAN_W-1:0]     threshold
);

  logic [CHAN_W-1:0] ref_blue_r;
  logic [CHAN_W-1:0] ref_green_r;
  logic [CHAN_W-1:0] ref_red_r;
  logic [CHAN_W-1:0] threshold_r;
  logic              wr_en;
  cfg_reg_t          reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_blue_r  <= RST_REF_BLUE;
      ref_green_r <= RST_REF_GREEN;
      ref_red_r   <= RST_REF_RED;
      threshold_r <= RST_THRESHOLD;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_REF_BLUE:        ref_blue_r  <= pwdata[CHAN_W-1:0];
        REG_REF_GREEN:       ref_green_r <= pwdata[CHAN_W-1:0];
        REG_REF_RED:         ref_red_r   <= pwdata[CHAN_W-1:0];
        REG_MATCH_THRESHOLD: threshold_r <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data is zero extended.
  always_comb begin
    unique case (reg_sel)
      REG_REF_BLUE:        prdata = CFG_DATA_W'(ref_blue_r);
      REG_REF_GREEN:       prdata = CFG_DATA_W'(ref_green_r);
      REG_REF_RED:         prdata = CFG_DATA_W'(ref_red_r);
      REG_MATCH_THRESHOLD: prdata = CFG_DATA_W'(threshold_r);
      default:             prdata = '0;
    endcase
  end

  assign key_color.blue  = ref_blue_r;
  assign key_color.green = ref_green_r;
  assign key_color.red   = ref_red_r;
  assign threshold       = threshold_r;

endmodule

FILE: src/ccm_norm_pipe.sv
// Pipelined chromaticity normalization: channel sum, restoring division, red fill-in.
module ccm_norm_pipe import ccm_pkg::*; (
  input  logic                   clk,
  input  logic [NORM_STAGES-1:0] stg_en,
  input  bgr_t                   raw,
  output bgr_t                   norm
);

  logic [SUM_W-1:0] sum_r   [DIV_STEPS+1];
  logic             zero_r  [DIV_STEPS+1];
  logic [NUM_W-1:0] rem_b_r [DIV_STEPS+1];
  logic [NUM_W-1:0] rem_g_r [DIV_STEPS+1];
  logic [QUO_W-1:0] quo_b_r [DIV_STEPS+1];
  logic [QUO_W-1:0] quo_g_r [DIV_STEPS+1];

  logic [SUM_W-1:0] sum_nxt;
  logic [NUM_W-1:0] num_b_nxt;
  logic [NUM_W-1:0] num_g_nxt;
  bgr_t             norm_nxt;
  bgr_t             norm_r;

  // Channel sum and numerators channel*255, formed as channel*256 - channel.
  always_comb begin
    sum_nxt   = SUM_W'(raw.blue) + SUM_W'(raw.green) + SUM_W'(raw.red);
    num_b_nxt = {raw.blue, 8'h00} - NUM_W'(raw.blue);
    num_g_nxt = {raw.green, 8'h00} - NUM_W'(raw.green);
  end

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      sum_r[0]   <= sum_nxt;
      zero_r[0]  <= (sum_nxt == '0);
      rem_b_r[0] <= num_b_nxt;
      rem_g_r[0] <= num_g_nxt;
      quo_b_r[0] <= '0;
      quo_g_r[0] <= '0;
    end
  end

  // One quotient bit per stage, most significant first. The quotient never
  // exceeds 255, so the numerator can serve directly as the first remainder.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - j;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] diff_b;
    logic [REM_W-1:0] diff_g;
    logic             ge_b;
    logic             ge_g;

    always_comb begin
      trial  = REM_W'(sum_r[j]) << SH;
      ge_b   = {1'b0, rem_b_r[j]} >= trial;
      ge_g   = {1'b0, rem_g_r[j]} >= trial;
      diff_b = {1'b0, rem_b_r[j]} - trial;
      diff_g = {1'b0, rem_g_r[j]} - trial;
    end

    always_ff @(posedge clk) begin
      if (stg_en[j+1]) begin
        sum_r[j+1]   <= sum_r[j];
        zero_r[j+1]  <= zero_r[j];
        rem_b_r[j+1] <= ge_b ? diff_b[NUM_W-1:0] : rem_b_r[j];
        rem_g_r[j+1] <= ge_g ? diff_g[NUM_W-1:0] : rem_g_r[j];
        quo_b_r[j+1] <= {quo_b_r[j][QUO_W-2:0], ge_b};
        quo_g_r[j+1] <= {quo_g_r[j][QUO_W-2:0], ge_g};
      end
    end
  end

  // Red takes what is left of 255; a black pixel stays black.
  always_comb begin
    if (zero_r[DIV_STEPS]) begin
      norm_nxt = '0;
    end else begin
      norm_nxt.blue  = quo_b_r[DIV_STEPS];
      norm_nxt.green = quo_g_r[DIV_STEPS];
      norm_nxt.red   = CHAN_FULL - quo_b_r[DIV_STEPS] - quo_g_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[NORM_STAGES-1]) begin
      norm_r <= norm_nxt;
    end
  end

  assign norm = norm_r;

endmodule

FILE: src/chromaticity_color_key_mask_unit.sv
// Top level of the chromaticity color key mask unit.
//
// Each request carries one BGR pixel and yields one result: the saturated L1
// distance between the pixel's chromaticity and that of the configured key
// color, and a mask of 255 when that distance is at most the threshold, else 0.
// The unit is a 13-stage pipeline that takes a new request in every clock
// cycle while the output is not stalled; a request passes through the entry,
// normalization, difference and output stages in turn. Two restoring dividers
// per color (blue and green) resolve one quotient bit per stage over eight
// stages. Each stage holds its item while downstream is full, so bubbles are
// squeezed out and input is still taken while a finished result waits.
// The key color and threshold are read from the register port (key blue at
// 0x0, green at 0x4, red at 0x8, threshold at 0xC) and must not be written
// while requests are in flight.
`include "chromaticity_color_key_mask_unit_defines.svh"

module chromaticity_color_key_mask_unit import ccm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Pixel input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAN_W-1:0]     in_blue,
  input  logic [CHAN_W-1:0]     in_green,
  input  logic [CHAN_W-1:0]     in_red,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAN_W-1:0]     out_mask,
  output logic [CHAN_W-1:0]     out_distance,
  // Register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Stage map: entry, normalization stages, difference, output.
  localparam int ST_ENTRY = 0;
  localparam int ST_NORM0 = 1;
  localparam int ST_DIFF  = ST_NORM0 + NORM_STAGES;
  localparam int ST_OUT   = ST_DIFF + 1;
  localparam int N_STG    = ST_OUT + 1;

  logic [N_STG-1:0]  vld_r;
  logic [N_STG-1:0]  stg_en;

  bgr_t              key_color;
  logic [CHAN_W-1:0] threshold;
  bgr_t              pix_r;
  bgr_t              key_r;
  bgr_t              pix_norm;
  bgr_t              key_norm;

  logic [CHAN_W-1:0] ad_b_nxt, ad_g_nxt, ad_r_nxt;
  logic [CHAN_W-1:0] ad_b_r, ad_g_r, ad_r_r;
  logic [SUM_W-1:0]  dist_sum;
  logic [CHAN_W-1:0] dist_nxt;
  logic [CHAN_W-1:0] dist_r;
  logic [CHAN_W-1:0] mask_nxt;
  logic [CHAN_W-1:0] mask_r;

  ccm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .key_color (key_color),
    .threshold (threshold)
  );

  // A stage may load when it is empty or its successor loads.
  always_comb begin
    stg_en[N_STG-1] = !vld_r[N_STG-1] || !out_stall;
    for (int k = N_STG - 2; k >= 0; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
  end

  assign in_stall = !stg_en[ST_ENTRY];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_en[ST_ENTRY]) begin
        vld_r[ST_ENTRY] <= in_valid;
      end
      for (int k = 1; k < N_STG; k++) begin
        if (stg_en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Entry register: pixel and the key color it is compared against.
  always_ff @(posedge clk) begin
    if (stg_en[ST_ENTRY]) begin
      pix_r.blue  <= in_blue;
      pix_r.green <= in_green;
      pix_r.red   <= in_red;
      key_r       <= key_color;
    end
  end

  ccm_norm_pipe u_pix_norm (
    .clk    (clk),
    .stg_en (stg_en[ST_DIFF-1:ST_NORM0]),
    .raw    (pix_r),
    .norm   (pix_norm)
  );

  ccm_norm_pipe u_key_norm (
    .clk    (clk),
    .stg_en (stg_en[ST_DIFF-1:ST_NORM0]),
    .raw    (key_r),
    .norm   (key_norm)
  );

  // Absolute channel differences.
  always_comb begin
    ad_b_nxt = (pix_norm.blue > key_norm.blue) ? pix_norm.blue - key_norm.blue
                                               : key_norm.blue - pix_norm.blue;
    ad_g_nxt = (pix_norm.green > key_norm.green) ? pix_norm.green - key_norm.green
                                                 : key_norm.green - pix_norm.green;
    ad_r_nxt = (pix_norm.red > key_norm.red) ? pix_norm.red - key_norm.red
                                             : key_norm.red - pix_norm.red;
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_DIFF]) begin
      ad_b_r <= ad_b_nxt;
      ad_g_r <= ad_g_nxt;
      ad_r_r <= ad_r_nxt;
    end
  end

  // Saturated distance and threshold compare into the output register.
  always_comb begin
    dist_sum = SUM_W'(ad_b_r) + SUM_W'(ad_g_r) + SUM_W'(ad_r_r);
    dist_nxt = (dist_sum > SUM_W'(CHAN_FULL)) ? CHAN_FULL : dist_sum[CHAN_W-1:0];
    mask_nxt = (dist_nxt <= threshold) ? MASK_ON : MASK_OFF;
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_OUT]) begin
      dist_r <= dist_nxt;
      mask_r <= mask_nxt;
    end
  end

  assign out_valid    = vld_r[ST_OUT];
  assign out_mask     = mask_r;
  assign out_distance = dist_r;

  // A full pipeline behind a stalled output takes no new request.
  `CCM_ASSERT_NOW(a_full_stall, (&vld_r) && out_stall, in_stall)
  // The mask is only ever fully on or fully off.
  `CCM_ASSERT_NOW(a_mask_code, out_valid, (out_mask == MASK_ON) || (out_mask == MASK_OFF))
  // A normalized pixel sums to 255 unless it is black.
  `CCM_ASSERT_NOW(a_norm_sum, vld_r[ST_DIFF-1],
    ((SUM_W'(pix_norm.blue) + SUM_W'(pix_norm.green) + SUM_W'(pix_norm.red))
      == SUM_W'(CHAN_FULL)) || (pix_norm == '0))

endmodule
